FILE: hw/rtl/sprv_pkg.sv
// Shared types, constants and helper functions for the stereo pan reverb block.
package sprv_pkg;

  // Sample format (signed Q1.15)
  localparam int SAMPLE_BITS = 16;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Payload of one input transfer and one output transfer
  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
  } in_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
  } out_t;

  // Configuration port
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_GAIN_L    = 3'd0,
    REG_GAIN_R    = 3'd1,
    REG_REVERB_ON = 3'd2,
    REG_ROOM      = 3'd3,
    REG_FEEDBACK  = 3'd4,
    REG_WET_GAIN  = 3'd5
  } reg_idx_t;

  localparam logic [15:0] GAIN_L_RST    = 16'd23170;
  localparam logic [15:0] GAIN_R_RST    = 16'd23170;
  localparam logic [15:0] ROOM_RST      = 16'd16384;
  localparam logic [14:0] FEEDBACK_RST  = 15'd11469;
  localparam logic [15:0] WET_GAIN_RST  = 16'd9830;

  // Q1.15 unity, also the clamp for room size and wet mix
  localparam logic [16:0] UNITY = 17'd32768;

  // Tap delay scaling: scale = SCALE_OFFSET + (SCALE_SPAN * room) >> 15, Q1.16
  localparam int SCALE_BITS = 17;
  localparam logic [SCALE_BITS-1:0] SCALE_OFFSET = 17'd19661;
  localparam logic [15:0]           SCALE_SPAN   = 16'd45875;
  localparam logic [SCALE_BITS-1:0] SCALE_RST    = 17'd42598;

  // Four taps per channel
  localparam int NUM_TAPS   = 4;
  localparam int TAP_BITS   = 2;
  localparam int DELAY_BITS = 11;
  localparam logic [NUM_TAPS-1:0][DELAY_BITS-1:0] TAP_BASE =
    {11'd1777, 11'd1511, 11'd1283, 11'd1087};

  // Right channel reads this many samples further back
  localparam logic [DELAY_BITS-1:0] RIGHT_EXTRA = 11'd23;

  // Wide intermediate width for mix sums
  localparam int WIDE_BITS = 36;
  localparam logic signed [WIDE_BITS-1:0] SAMPLE_HI =
    WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_BITS-1:0] SAMPLE_LO = -SAMPLE_HI - 36'sd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_MUL,
    ST_FIN
  } state_t;

  // Stage enables from the sequencer to each channel datapath
  typedef struct packed {
    logic gain_en;
    logic dry_en;
    logic acc_clr;
    logic acc_en;
    logic mul_en;
  } mix_ctl_t;

  // Configuration values used by the datapath
  typedef struct packed {
    logic [15:0] gain_l;
    logic [15:0] gain_r;
    logic        reverb_on;
    logic [14:0] feedback_gain;
    logic [15:0] wet_gain;
  } cfg_t;

  // Saturate a wide signed value to the sample range
  function automatic sample_t sat_sample(input logic signed [WIDE_BITS-1:0] v);
    sample_t r;
    if (v > SAMPLE_HI) begin
      r = SAMPLE_HI[SAMPLE_BITS-1:0];
    end else if (v < SAMPLE_LO) begin
      r = SAMPLE_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/stereo_pan_multitap_reverb_top.sv
// Top level of the stereo pan and multitap feedback delay reverb.
//
// Usage: one stereo sample pair enters on in_data per input transfer
// (in_valid high, in_stall low at a rising clk edge); one gained and mixed
// pair leaves on out_data per output transfer (out_valid high, out_stall low).
// Gains, reverb enable, room size, feedback and wet mix are written through
// the APB port; the user must write them only while no item is in flight,
// as the block itself does not enforce this.
// A new item is taken only after the previous one has passed the sequencer
// states: four sequential tap reads (ST_READ) through the single read port of
// each delay memory, ST_LAST, the multiply (ST_MUL) and output load (ST_FIN).
// The output register decouples the sides: a new item is taken while the
// previous result still waits. If the receiver stalls, the finished item
// holds in the last stage and input stays stalled until the register frees.
// Reset: a clearing pass zeroes both delay memories, one entry per cycle,
// over all DELAY_DEPTH entries; in_stall stays high during it. Configuration
// writes are taken throughout.
module stereo_pan_multitap_reverb_top #(
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sprv_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sprv_pkg::out_t                     out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sprv_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [sprv_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [sprv_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sprv_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW+1)'(DELAY_DEPTH);

  cfg_t                              cfg;
  logic [NUM_TAPS-1:0][DELAY_BITS-1:0] tap_delays;

  state_t                state, state_next;
  logic [TAP_BITS-1:0]   k, k_next;
  logic [AW-1:0]         clr_cnt, clr_cnt_next;
  logic [AW-1:0]         wp, wp_next;
  in_t                   samples;
  mix_ctl_t              ctl;
  logic                  out_load;
  logic                  mem_we;
  logic [AW-1:0]         waddr;
  sample_t               wdata_l, wdata_r;
  logic [AW-1:0]         raddr_l, raddr_r;
  sample_t               rdata_l, rdata_r;
  sample_t               store_l, store_r;
  sample_t               mix_l, mix_r;
  logic [AW:0]           back_l, back_r;
  logic [AW:0]           diff_l, diff_r;

  sprv_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .tap_delays (tap_delays)
  );

  // Tap addresses behind the write position; delays stay below the depth
  always_comb begin
    back_l  = (AW+1)'(tap_delays[k]);
    back_r  = (AW+1)'(tap_delays[k]) + (AW+1)'(RIGHT_EXTRA);
    diff_l  = {1'b0, wp} - back_l;
    diff_r  = {1'b0, wp} - back_r;
    raddr_l = diff_l[AW] ? AW'(diff_l + DEPTH_W) : diff_l[AW-1:0];
    raddr_r = diff_r[AW] ? AW'(diff_r + DEPTH_W) : diff_r[AW-1:0];
  end

  // Memory write: clearing pass or the item's store value
  always_comb begin
    waddr   = (state == ST_CLEAR) ? clr_cnt : wp;
    wdata_l = (state == ST_CLEAR) ? '0 : store_l;
    wdata_r = (state == ST_CLEAR) ? '0 : store_r;
  end

  sprv_delay_mem #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_mem_l (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata_l),
    .raddr (raddr_l),
    .rdata (rdata_l)
  );

  sprv_delay_mem #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_mem_r (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata_r),
    .raddr (raddr_r),
    .rdata (rdata_r)
  );

  sprv_mix u_mix_l (
    .clk           (clk),
    .ctl           (ctl),
    .sample        (samples.sample_left),
    .gain          (cfg.gain_l),
    .rdata         (rdata_l),
    .feedback_gain (cfg.feedback_gain),
    .wet_gain      (cfg.wet_gain),
    .reverb_on     (cfg.reverb_on),
    .store_val     (store_l),
    .out_val       (mix_l)
  );

  sprv_mix u_mix_r (
    .clk           (clk),
    .ctl           (ctl),
    .sample        (samples.sample_right),
    .gain          (cfg.gain_r),
    .rdata         (rdata_r),
    .feedback_gain (cfg.feedback_gain),
    .wet_gain      (cfg.wet_gain),
    .reverb_on     (cfg.reverb_on),
    .store_val     (store_r),
    .out_val       (mix_r)
  );

  // Sequencer: next state and stage controls
  always_comb begin
    state_next   = state;
    k_next       = k;
    clr_cnt_next = clr_cnt;
    wp_next      = wp;
    ctl          = '0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    in_stall     = 1'b1;
    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_READ;
          k_next     = '0;
        end
      end
      ST_READ: begin
        ctl.gain_en = (k == 2'd0);
        ctl.dry_en  = (k == 2'd1);
        ctl.acc_clr = (k == 2'd0);
        ctl.acc_en  = (k != 2'd0);
        k_next      = k + 1'b1;
        if (k == TAP_BITS'(NUM_TAPS - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        ctl.acc_en = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (cfg.reverb_on) begin
            mem_we  = 1'b1;
            wp_next = (wp == LAST_ADDR) ? '0 : wp + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      k         <= '0;
      clr_cnt   <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      clr_cnt <= clr_cnt_next;
      wp      <= wp_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input capture and output register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      samples <= in_data;
    end
    if (out_load) begin
      out_data.out_left  <= mix_l;
      out_data.out_right <= mix_r;
    end
  end

`ifndef ASSERT_OFF
  // Every input transfer starts the tap reads at the first tap
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_READ && k == 2'd0))
    else $error("accepted item did not start tap reads");

  // No input transfer while the delay memories are being cleared
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // Write position moves only with a store write at the end of an item
  a_wp_moves: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_FIN && mem_we) |=> $stable(wp))
    else $error("write position changed without a store write");

  // A tap never reads the entry about to be written
  a_tap_not_wp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (raddr_l != wp && raddr_r != wp))
    else $error("tap address equals write position");
`endif

endmodule

FILE: hw/rtl/sprv_cfg_regs.sv
// APB register file and tap delay computation.
module sprv_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sprv_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [sprv_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [sprv_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                   pready,
  output sprv_pkg::cfg_t                         cfg,
  output logic [sprv_pkg::NUM_TAPS-1:0][sprv_pkg::DELAY_BITS-1:0] tap_delays
);
  import sprv_pkg::*;

  logic [15:0]           room;
  logic [SCALE_BITS-1:0] scale;
  logic                  wr;
  reg_idx_t              idx;
  logic [16:0]           room_c;
  logic [31:0]           room_prod;
  logic [SCALE_BITS-1:0] scale_new;
  logic [27:0]           tap_prod [NUM_TAPS];

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  // Clamped room size to scale factor
  always_comb begin
    room_c    = (pwdata[15:0] > UNITY[15:0] && pwdata[15]) ? UNITY : {1'b0, pwdata[15:0]};
    room_prod = 32'(room_c) * 32'(SCALE_SPAN);
    scale_new = SCALE_OFFSET + room_prod[31:15];
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_l        <= GAIN_L_RST;
      cfg.gain_r        <= GAIN_R_RST;
      cfg.reverb_on     <= 1'b0;
      cfg.feedback_gain <= FEEDBACK_RST;
      cfg.wet_gain      <= WET_GAIN_RST;
      room              <= ROOM_RST;
      scale             <= SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_GAIN_L:     cfg.gain_l        <= pwdata[15:0];
        REG_GAIN_R:     cfg.gain_r        <= pwdata[15:0];
        REG_REVERB_ON:  cfg.reverb_on     <= pwdata[0];
        REG_ROOM: begin
          room  <= pwdata[15:0];
          scale <= scale_new;
        end
        REG_FEEDBACK:   cfg.feedback_gain <= pwdata[14:0];
        REG_WET_GAIN:   cfg.wet_gain      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Tap delays are registered from the scale and follow it in the next cycle
  always_comb begin
    for (int d = 0; d < NUM_TAPS; d++) begin
      tap_prod[d] = 28'(TAP_BASE[d]) * 28'(scale);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_TAPS; d++) begin
      tap_delays[d] <= tap_prod[d][26:16];
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_GAIN_L:     prdata = 32'(cfg.gain_l);
      REG_GAIN_R:     prdata = 32'(cfg.gain_r);
      REG_REVERB_ON:  prdata = 32'(cfg.reverb_on);
      REG_ROOM:       prdata = 32'(room);
      REG_FEEDBACK:   prdata = 32'(cfg.feedback_gain);
      REG_WET_GAIN:   prdata = 32'(cfg.wet_gain);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/sprv_delay_mem.sv
// One circular delay store: one write port, one registered read port.
module sprv_delay_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  sprv_pkg::sample_t wdata,
  input  logic [AW-1:0]     raddr,
  output sprv_pkg::sample_t rdata
);
  import sprv_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sprv_mix.sv
// Per-channel datapath: gain, tap accumulate, feedback and wet/dry mix.
module sprv_mix (
  input  logic                clk,
  input  sprv_pkg::mix_ctl_t  ctl,
  input  sprv_pkg::sample_t   sample,
  input  logic [15:0]         gain,
  input  sprv_pkg::sample_t   rdata,
  input  logic [14:0]         feedback_gain,
  input  logic [15:0]         wet_gain,
  input  logic                reverb_on,
  output sprv_pkg::sample_t   store_val,
  output sprv_pkg::sample_t   out_val
);
  import sprv_pkg::*;

  logic signed [32:0]          gain_prod;
  sample_t                     dry;
  logic signed [17:0]          acc;
  logic signed [33:0]          fb_prod;
  logic signed [33:0]          dry_prod;
  logic signed [33:0]          wet_prod;

  logic signed [16:0]          gain_s;
  logic signed [15:0]          fb_s;
  logic [16:0]                 wet_c;
  logic signed [17:0]          wet_s;
  logic signed [17:0]          drymix_s;
  logic signed [32:0]          gain_rnd;
  logic signed [33:0]          fb_rnd;
  logic signed [WIDE_BITS-1:0] store_sum;
  logic signed [WIDE_BITS-1:0] out_sum;

  // Operand preparation, wet clamped to unity
  always_comb begin
    gain_s   = $signed({1'b0, gain});
    fb_s     = $signed({1'b0, feedback_gain});
    wet_c    = ({1'b0, wet_gain} > UNITY) ? UNITY : {1'b0, wet_gain};
    wet_s    = $signed({1'b0, wet_c});
    drymix_s = $signed({1'b0, UNITY - (wet_c >> 1)});
    gain_rnd = gain_prod + 33'sd16384;
  end

  // Gain product, then rounded and saturated dry sample
  always_ff @(posedge clk) begin
    if (ctl.gain_en) begin
      gain_prod <= sample * gain_s;
    end
    if (ctl.dry_en) begin
      dry <= sat_sample(WIDE_BITS'(gain_rnd >>> 15));
    end
  end

  // Tap sum
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + 18'(rdata);
    end
  end

  // Feedback, dry and wet products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      fb_prod  <= acc * fb_s;
      dry_prod <= dry * drymix_s;
      wet_prod <= acc * wet_s;
    end
  end

  // Round, sum and saturate
  always_comb begin
    fb_rnd    = fb_prod + 34'sd65536;
    store_sum = WIDE_BITS'(dry) + WIDE_BITS'(fb_rnd >>> 17);
    out_sum   = (WIDE_BITS'(dry_prod) <<< 2) + WIDE_BITS'(wet_prod) + 36'sd65536;
    store_val = sat_sample(store_sum);
    out_val   = reverb_on ? sat_sample(out_sum >>> 17) : dry;
  end

endmodule

FILE: dv/tb_stereo_pan_multitap_reverb_top.sv
// Self-checking testbench for the stereo pan and multitap feedback delay reverb block.
module tb_stereo_pan_multitap_reverb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sprv_pkg::*;

  localparam int ECHO_DEPTH      = 2048;
  localparam int RIGHT_LAG       = 23;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES   = 16;
  localparam logic [NUM_TAPS-1:0][10:0] ECHO_BASE = {11'd1777, 11'd1511, 11'd1283, 11'd1087};

  // Register slots past the last defined one; writes there must be dropped
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // One row of the directed table: a register write or a sample transfer
  typedef struct packed {
    logic       is_cfg;
    logic [2:0] sel;
    logic [31:0] wval;
    in_t        smp;
    logic       typed;
    out_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  stereo_pan_multitap_reverb_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: register copies, echo stores, write pointer, tap lengths
  logic [15:0] gain_l, gain_r, room, wet;
  logic [14:0] fb;
  logic        verb_en;
  sample_t     echo_l [ECHO_DEPTH];
  sample_t     echo_r [ECHO_DEPTH];
  int          wr_pos;
  int          tap_len [NUM_TAPS];

  out_t     pending_mix [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;
  int       rx_hold = 0;
  int       rx_roll;

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic sample_t clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // Tap lengths follow room size, clamped to one
  function automatic void retune_taps();
    longint r;
    longint sc;
    r = (room > 16'd32768) ? 32768 : longint'(room);
    sc = 19661 + ((longint'(45875) * r) >>> 15);
    for (int k = 0; k < NUM_TAPS; k++) begin
      tap_len[k] = int'((longint'(ECHO_BASE[k]) * sc) >>> 16);
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_GAIN_L:     gain_l = v[15:0];
      REG_GAIN_R:     gain_r = v[15:0];
      REG_REVERB_ON:  verb_en = v[0];
      REG_ROOM: begin
        room = v[15:0];
        retune_taps();
      end
      REG_FEEDBACK:   fb = v[14:0];
      REG_WET_GAIN:   wet = v[15:0];
      default: ;
    endcase
  endfunction

  // Gain, tap sums, store update and wet/dry mix for one stereo pair
  function automatic out_t predict_mix(in_t s);
    longint dl, dr, sl, sr, wv, dv;
    int     pl, pr;
    out_t   r;
    dl = clip16(rnd_shift(longint'(s.sample_left) * longint'(gain_l), 15));
    dr = clip16(rnd_shift(longint'(s.sample_right) * longint'(gain_r), 15));
    r.out_left = sample_t'(dl);
    r.out_right = sample_t'(dr);
    if (!verb_en) return r;
    wv = (wet > 16'd32768) ? 32768 : longint'(wet);
    dv = 32768 - (wv >>> 1);
    sl = 0;
    sr = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      pl = (wr_pos + ECHO_DEPTH - (tap_len[k] % ECHO_DEPTH)) % ECHO_DEPTH;
      pr = (wr_pos + ECHO_DEPTH - ((tap_len[k] + RIGHT_LAG) % ECHO_DEPTH)) % ECHO_DEPTH;
      sl += longint'(echo_l[pl]);
      sr += longint'(echo_r[pr]);
    end
    echo_l[wr_pos] = clip16(dl + rnd_shift(sl * longint'(fb), 17));
    echo_r[wr_pos] = clip16(dr + rnd_shift(sr * longint'(fb), 17));
    r.out_left = clip16(rnd_shift(4 * dl * dv + sl * wv, 17));
    r.out_right = clip16(rnd_shift(4 * dr * dv + sr * wv, 17));
    wr_pos = (wr_pos + 1) % ECHO_DEPTH;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [2:0] sel, logic [31:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.sel = sel;
    row.wval = v;
    return row;
  endfunction

  function automatic dir_row_t mix_row(int l, int r, bit typed, int el, int er);
    dir_row_t row;
    row = '0;
    row.smp.sample_left = sample_t'(l);
    row.smp.sample_right = sample_t'(r);
    row.typed = typed;
    row.want.out_left = sample_t'(el);
    row.want.out_right = sample_t'(er);
    return row;
  endfunction

  function automatic logic [15:0] pick_level(int top, int ones);
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'(top);
      2: return 16'(ones);
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  // Register word with junk in the bits above the field
  function automatic logic [31:0] cfg_word(logic [15:0] v);
    logic [31:0] junk;
    junk = $urandom;
    return {junk[31:16], v};
  endfunction

  function automatic sample_t pick_edge();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Mostly full-range stereo, some edge values, some mono pairs
  function automatic in_t pick_pair();
    in_t s;
    int  k;
    k = $urandom_range(0, 19);
    s.sample_left = sample_t'($urandom);
    s.sample_right = sample_t'($urandom);
    if (k < 2) begin
      s.sample_left = pick_edge();
      s.sample_right = pick_edge();
    end else if (k < 5) begin
      s.sample_right = s.sample_left;
    end
    return s;
  endfunction

  function automatic int tx_gap();
    int k;
    if (tx_calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Lower valid and wait until every expected result has been taken
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    wait_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, v);
    @(posedge clk);
  endtask

  // One input transfer; the expectation is queued when it is taken
  task automatic send_mix(in_t x, int gap, bit hold, bit typed, out_t typed_val);
    out_t want;
    if (hold) begin
      wait_drain();
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    want = predict_mix(x);
    pending_mix.push_back(typed ? typed_val : want);
  endtask

  // Receiver stall: mostly short, a few long, none in calm phases
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 60) begin
        out_stall <= 1'b0;
      end else if (rx_roll < 90) begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Output transfers against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_mix.size() == 0) begin
        $error("unexpected output transfer: out_left %0d out_right %0d",
               out_data.out_left, out_data.out_right);
        mismatch_count++;
      end else begin
        want = pending_mix.pop_front();
        if (out_data.out_left !== want.out_left) begin
          $error("out_left: expected %0d, got %0d", want.out_left, out_data.out_left);
          mismatch_count++;
        end
        if (out_data.out_right !== want.out_right) begin
          $error("out_right: expected %0d, got %0d", want.out_right, out_data.out_right);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [15:0] lv;

    // Directed table; rows with typed results are read straight off the math
    dir_rows.push_back(mix_row(0, 0, 1, 0, 0));
    dir_rows.push_back(mix_row(32767, -32768, 1, 23169, -23170));
    dir_rows.push_back(mix_row(-32768, 32767, 1, -23170, 23169));
    dir_rows.push_back(mix_row(1, -1, 1, 1, -1));
    dir_rows.push_back(mix_row(12345, 12345, 0, 0, 0));
    // gain above one saturates, zero gain mutes
    dir_rows.push_back(cfg_row(REG_GAIN_L, 32'd65535));
    dir_rows.push_back(cfg_row(REG_GAIN_R, 32'd0));
    dir_rows.push_back(mix_row(32767, -32768, 1, 32767, 0));
    dir_rows.push_back(mix_row(-32768, 32767, 1, -32768, 0));
    dir_rows.push_back(mix_row(-20000, -20000, 0, 0, 0));
    // unity gain, then writes to unused slots that must change nothing
    dir_rows.push_back(cfg_row(REG_GAIN_L, 32'd32768));
    dir_rows.push_back(cfg_row(REG_GAIN_R, 32'd32768));
    dir_rows.push_back(cfg_row(REG_SPARE_A, 32'd0));
    dir_rows.push_back(cfg_row(REG_SPARE_B, 32'd0));
    dir_rows.push_back(mix_row(-32768, 32767, 1, -32768, 32767));
    dir_rows.push_back(mix_row(100, -100, 1, 100, -100));
    // reverb on with room, feedback and wet past their ranges; stores empty
    dir_rows.push_back(cfg_row(REG_REVERB_ON, 32'd1));
    dir_rows.push_back(cfg_row(REG_ROOM, 32'd65535));
    dir_rows.push_back(cfg_row(REG_FEEDBACK, 32'd32767));
    dir_rows.push_back(cfg_row(REG_WET_GAIN, 32'd65535));
    dir_rows.push_back(mix_row(32767, -32768, 1, 16384, -16384));
    dir_rows.push_back(mix_row(-1, 1, 1, 0, 1));
    dir_rows.push_back(mix_row(20000, -7, 0, 0, 0));
    dir_rows.push_back(mix_row(-32768, -32768, 0, 0, 0));
    // shortest taps, no feedback, fully dry
    dir_rows.push_back(cfg_row(REG_ROOM, 32'd0));
    dir_rows.push_back(cfg_row(REG_FEEDBACK, 32'd0));
    dir_rows.push_back(cfg_row(REG_WET_GAIN, 32'd0));
    dir_rows.push_back(mix_row(32767, 32767, 0, 0, 0));
    dir_rows.push_back(mix_row(-12000, 8000, 0, 0, 0));
    dir_rows.push_back(mix_row(0, -32768, 0, 0, 0));
    dir_rows.push_back(mix_row(7, 7, 0, 0, 0));
    // room and wet at exactly one, top nominal feedback
    dir_rows.push_back(cfg_row(REG_ROOM, 32'd32768));
    dir_rows.push_back(cfg_row(REG_FEEDBACK, 32'd22708));
    dir_rows.push_back(cfg_row(REG_WET_GAIN, 32'd32768));
    dir_rows.push_back(mix_row(-32768, 32767, 0, 0, 0));
    dir_rows.push_back(mix_row(5000, -5000, 0, 0, 0));

    // Predictor after reset
    gain_l = GAIN_L_RST;
    gain_r = GAIN_R_RST;
    verb_en = 1'b0;
    room = ROOM_RST;
    fb = FEEDBACK_RST;
    wet = WET_GAIN_RST;
    for (int i = 0; i < ECHO_DEPTH; i++) begin
      echo_l[i] = '0;
      echo_r[i] = '0;
    end
    wr_pos = 0;
    retune_taps();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        reg_write(row.sel, row.wval);
      end else begin
        send_mix(row.smp, tx_gap(), 1'b0, row.typed, row.want);
      end
    end

    // Random phases, each with a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      reg_write(REG_GAIN_L, cfg_word(pick_level(32768, 65535)));
      reg_write(REG_GAIN_R, cfg_word(pick_level(32768, 65535)));
      reg_write(REG_REVERB_ON, cfg_word({15'($urandom), ($urandom_range(0, 6) != 0)}));
      lv = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 8192)) : pick_level(32768, 65535);
      reg_write(REG_ROOM, cfg_word(lv));
      lv = pick_level(22708, 32767);
      lv[15] = $urandom_range(0, 1);
      reg_write(REG_FEEDBACK, cfg_word(lv));
      reg_write(REG_WET_GAIN, cfg_word(pick_level(32768, 65535)));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_mix(pick_pair(), tx_gap(), (p == 0 && i == 60) || ($urandom_range(0, 199) == 0),
                 1'b0, '0);
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
